>>> sv/hfmc_pkg.sv
// ----------------------------------------------------------------------------
// hfmc_pkg
// Shared types and constants for the humidity fan mode controller.
// ----------------------------------------------------------------------------
package hfmc_pkg;

    localparam int TIME_W_DEF = 62;
    localparam int LIMIT_W    = 40;
    localparam int HUM_W      = 10;
    localparam int OP_W       = 2;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;

    // modes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COOL   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FORCED = 2'd2;
    localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd3;

    // operations
    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_MAN_ON  = 2'd1;
    localparam logic [OP_W-1:0] OP_MAN_OFF = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_INT = 2'd3;

    // register reset values
    localparam logic [HUM_W-1:0]   THRESHOLD_RST = 10'd700;
    localparam logic [LIMIT_W-1:0] RUN_LIMIT_RST = 40'd1800000000;
    localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST = 40'd7200000000;
    localparam logic [LIMIT_W-1:0] FORCE_INT_RST = 40'd21600000000;

    typedef struct packed {
        logic [HUM_W-1:0]   threshold;
        logic [LIMIT_W-1:0] run_limit;
        logic [LIMIT_W-1:0] wait_limit;
        logic [LIMIT_W-1:0] force_int;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic               fan_drive;
        logic [LIMIT_W-1:0] remaining_us;
        logic               changed;
    } t_res;

endpackage

>>> sv/hfmc_in_if.sv
// ----------------------------------------------------------------------------
// hfmc_in_if
// Input item channel: operation, humidity sample and timestamp.
// ----------------------------------------------------------------------------
interface hfmc_in_if #(
    parameter int TIME_WIDTH = hfmc_pkg::TIME_W_DEF
);
    logic                            valid;
    logic                            ready;
    logic [hfmc_pkg::OP_W-1:0]       op;
    logic [hfmc_pkg::HUM_W-1:0]      humidity_tenths;
    logic [TIME_WIDTH-1:0]           now_us;

    modport source (output valid, op, humidity_tenths, now_us, input ready);
    modport sink   (input valid, op, humidity_tenths, now_us, output ready);
endinterface

>>> sv/hfmc_out_if.sv
// ----------------------------------------------------------------------------
// hfmc_out_if
// Result item channel: mode, fan drive, remaining time and change flag.
// ----------------------------------------------------------------------------
interface hfmc_out_if;
    logic                             valid;
    logic                             ready;
    logic [hfmc_pkg::MODE_W-1:0]      mode;
    logic                             fan_drive;
    logic [hfmc_pkg::LIMIT_W-1:0]     remaining_us;
    logic                             changed;

    modport source (output valid, mode, fan_drive, remaining_us, changed, input ready);
    modport sink   (input valid, mode, fan_drive, remaining_us, changed, output ready);
endinterface

>>> sv/humidity_fan_mode_controller.sv
// ----------------------------------------------------------------------------
// humidity_fan_mode_controller
// Four-mode fan controller (idle, cooling, forced run, waiting) driven by
// timestamped humidity samples and manual on/off commands.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result side does not stall and returns one
// result per item: the item is captured in an input register, then the mode and
// timestamp update plus the remaining-time calculation run on it and land in the
// result register once that is free. The mode update loop finishes each item
// before the next one reads the state. A stalled result register holds one item
// while the input register holds the next. Configuration writes take effect on
// the next cycle.
module humidity_fan_mode_controller #(
    parameter int TIME_WIDTH = hfmc_pkg::TIME_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    hfmc_in_if.sink                          i_item,
    hfmc_out_if.source                       o_res,
    input  logic                             i_cfg_we,
    input  logic [hfmc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hfmc_pkg::LIMIT_W-1:0]     i_cfg_data
);
    import hfmc_pkg::*;

    t_cfg cfg;
    t_res step_res;

    logic                  r_s1_valid;
    logic [OP_W-1:0]       r_op;
    logic [HUM_W-1:0]      r_hum;
    logic [TIME_WIDTH-1:0] r_now;
    logic                  r_out_valid;
    t_res                  r_res;
    logic                  out_free, adv;

    assign out_free     = !r_out_valid || o_res.ready;
    assign adv          = r_s1_valid && out_free;
    assign i_item.ready = !r_s1_valid || out_free;

    hfmc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    hfmc_step #(.TIME_WIDTH(TIME_WIDTH)) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_op    (r_op),
        .i_hum   (r_hum),
        .i_now   (r_now),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_op  <= i_item.op;
            r_hum <= i_item.humidity_tenths;
            r_now <= i_item.now_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= step_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.mode         = r_res.mode;
    assign o_res.fan_drive    = r_res.fan_drive;
    assign o_res.remaining_us = r_res.remaining_us;
    assign o_res.changed      = r_res.changed;

    // fan runs exactly in cooling and forced modes
    a_fan_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.fan_drive ==
                         (o_res.mode == MODE_COOL || o_res.mode == MODE_FORCED)))
        else $error("fan drive disagrees with mode");

    // manual off always lands in idle
    a_man_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_op == OP_MAN_OFF) |=> (o_res.valid && o_res.mode == MODE_IDLE))
        else $error("manual off did not reach idle");

    // both stages full and result stalled: no room for another item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_res.ready) |-> !i_item.ready)
        else $error("item accepted with both stages full");
endmodule

>>> sv/hfmc_cfg.sv
// ----------------------------------------------------------------------------
// hfmc_cfg
// Configuration registers: humidity threshold and the three duration limits.
// ----------------------------------------------------------------------------
module hfmc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hfmc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [hfmc_pkg::LIMIT_W-1:0]     i_cfg_data,
    output hfmc_pkg::t_cfg                   o_cfg
);
    import hfmc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold  <= THRESHOLD_RST;
            r_cfg.run_limit  <= RUN_LIMIT_RST;
            r_cfg.wait_limit <= WAIT_LIMIT_RST;
            r_cfg.force_int  <= FORCE_INT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD:  r_cfg.threshold  <= i_cfg_data[HUM_W-1:0];
                CFG_RUN_LIMIT:  r_cfg.run_limit  <= i_cfg_data;
                CFG_WAIT_LIMIT: r_cfg.wait_limit <= i_cfg_data;
                CFG_FORCE_INT:  r_cfg.force_int  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

>>> sv/hfmc_step.sv
// ----------------------------------------------------------------------------
// hfmc_step
// Mode state, phase timestamps and the next-state / remaining-time logic
// for one item.
// ----------------------------------------------------------------------------
module hfmc_step #(
    parameter int TIME_WIDTH = hfmc_pkg::TIME_W_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic [hfmc_pkg::OP_W-1:0]    i_op,
    input  logic [hfmc_pkg::HUM_W-1:0]   i_hum,
    input  logic [TIME_WIDTH-1:0]        i_now,
    input  hfmc_pkg::t_cfg               i_cfg,
    output hfmc_pkg::t_res               o_res
);
    import hfmc_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > LIMIT_W) ? TIME_WIDTH : LIMIT_W;

    logic [MODE_W-1:0]     r_mode, n_mode;
    logic                  r_fan, n_fan;
    logic [TIME_WIDTH-1:0] r_last, r_run, r_wait;
    logic                  set_last, set_run, set_wait;

    logic [CMP_W-1:0] el_last, el_run, el_wait;
    logic [CMP_W-1:0] lim_run, lim_wait, lim_force;
    logic [LIMIT_W-1:0] rem_last, rem_run, rem_wait;
    logic             high, low, run_over, wait_over, force_over;

    // elapsed time, zero when time runs backwards
    assign el_last = (i_now >= r_last) ? CMP_W'(i_now - r_last) : '0;
    assign el_run  = (i_now >= r_run)  ? CMP_W'(i_now - r_run)  : '0;
    assign el_wait = (i_now >= r_wait) ? CMP_W'(i_now - r_wait) : '0;

    assign lim_run   = CMP_W'(i_cfg.run_limit);
    assign lim_wait  = CMP_W'(i_cfg.wait_limit);
    assign lim_force = CMP_W'(i_cfg.force_int);

    assign run_over   = el_run  > lim_run;
    assign wait_over  = el_wait > lim_wait;
    assign force_over = el_last > lim_force;

    assign high = i_hum > i_cfg.threshold;
    assign low  = i_hum < i_cfg.threshold;

    // time left from the stored timestamps; a restarted phase reads the full limit
    assign rem_run  = (el_run >= lim_run) ? '0 :
                      i_cfg.run_limit - el_run[LIMIT_W-1:0];
    assign rem_wait = (el_wait >= lim_wait) ? '0 :
                      i_cfg.wait_limit - el_wait[LIMIT_W-1:0];
    assign rem_last = (el_last >= lim_force) ? '0 :
                      i_cfg.force_int - el_last[LIMIT_W-1:0];

    always_comb begin
        n_mode   = r_mode;
        n_fan    = r_fan;
        set_last = 1'b0;
        set_run  = 1'b0;
        set_wait = 1'b0;
        case (i_op)
            OP_MAN_ON: begin
                n_mode  = MODE_COOL;
                n_fan   = 1'b1;
                set_run = 1'b1;
            end
            OP_MAN_OFF: begin
                n_mode   = MODE_IDLE;
                n_fan    = 1'b0;
                set_last = 1'b1;
            end
            OP_SAMPLE: begin
                unique case (r_mode)
                    MODE_IDLE: begin
                        if (high) begin
                            n_mode   = MODE_COOL;
                            n_fan    = 1'b1;
                            set_run  = 1'b1;
                            set_last = 1'b1;
                        end else if (force_over) begin
                            n_mode  = MODE_FORCED;
                            n_fan   = 1'b1;
                            set_run = 1'b1;
                        end
                    end
                    MODE_COOL: begin
                        if (run_over || low) begin
                            n_mode   = MODE_WAIT;
                            n_fan    = 1'b0;
                            set_wait = 1'b1;
                        end
                    end
                    MODE_FORCED: begin
                        if (run_over) begin
                            n_mode   = MODE_IDLE;
                            n_fan    = 1'b0;
                            set_last = 1'b1;
                        end
                    end
                    MODE_WAIT: begin
                        if (wait_over) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.mode      = n_mode;
        o_res.fan_drive = n_fan;
        o_res.changed   = (n_mode != r_mode);
        unique case (n_mode)
            MODE_COOL, MODE_FORCED:
                o_res.remaining_us = set_run ? i_cfg.run_limit : rem_run;
            MODE_WAIT:
                o_res.remaining_us = set_wait ? i_cfg.wait_limit : rem_wait;
            default:
                o_res.remaining_us = set_last ? i_cfg.force_int : rem_last;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_fan  <= 1'b0;
            r_last <= '0;
            r_run  <= '0;
            r_wait <= '0;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_fan  <= n_fan;
            if (set_last) r_last <= i_now;
            if (set_run)  r_run  <= i_now;
            if (set_wait) r_wait <= i_now;
        end
    end
endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for humidity_fan_mode_controller: directed mode and
// limit corners, then randomized sample / manual sequences under several
// register settings, with random input gaps and result back-pressure.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hfmc_pkg::*;

    localparam int                 TW         = TIME_W_DEF;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX  = '1;
    localparam logic [TW-1:0]      TIME_MAX   = '1;
    localparam int                 REPORT_CAP = 100;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LIMIT_W-1:0]   i_cfg_data;

    hfmc_in_if #(.TIME_WIDTH(TW)) item_if ();
    hfmc_out_if                   res_if ();

    humidity_fan_mode_controller #(.TIME_WIDTH(TW)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predicted controller state and registers
    logic [HUM_W-1:0]   thr_q;
    logic [LIMIT_W-1:0] run_lim_q;
    logic [LIMIT_W-1:0] wait_lim_q;
    logic [LIMIT_W-1:0] force_int_q;
    logic [MODE_W-1:0]  mode_q;
    logic               fan_q;
    logic [TW-1:0]      last_humid_q;
    logic [TW-1:0]      run_start_q;
    logic [TW-1:0]      wait_start_q;

    t_res          pending_results[$];
    int            mismatches  = 0;
    int            reports     = 0;
    int            hold_cycles = 0;
    bit            no_gaps     = 1'b0;
    bit            no_stall    = 1'b0;
    logic [TW-1:0] cur_time;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // time since a stored stamp; a stamp in the future counts as zero
    function automatic logic [63:0] elapsed_us(input logic [TW-1:0] now_t,
                                               input logic [TW-1:0] start_t);
        return (now_t >= start_t) ? 64'(now_t - start_t) : 64'd0;
    endfunction

    function automatic logic [LIMIT_W-1:0] time_left(input logic [LIMIT_W-1:0] lim,
                                                     input logic [63:0] spent);
        return (spent >= 64'(lim)) ? '0 : LIMIT_W'(64'(lim) - spent);
    endfunction

    function automatic t_res fan_predict(input logic [OP_W-1:0]  op,
                                         input logic [HUM_W-1:0] hum,
                                         input logic [TW-1:0]    now_t);
        t_res              r;
        logic [MODE_W-1:0] prev;
        logic              high;
        prev = mode_q;
        high = hum > thr_q;
        case (op)
            OP_MAN_ON: begin
                mode_q      = MODE_COOL;
                fan_q       = 1'b1;
                run_start_q = now_t;
            end
            OP_MAN_OFF: begin
                mode_q       = MODE_IDLE;
                fan_q        = 1'b0;
                last_humid_q = now_t;
            end
            OP_SAMPLE: begin
                case (mode_q)
                    MODE_IDLE: begin
                        if (high) begin
                            mode_q      = MODE_COOL;
                            fan_q       = 1'b1;
                            run_start_q = now_t;
                        end else if (elapsed_us(now_t, last_humid_q) > 64'(force_int_q)) begin
                            mode_q      = MODE_FORCED;
                            fan_q       = 1'b1;
                            run_start_q = now_t;
                        end
                        if (high) last_humid_q = now_t;
                    end
                    MODE_COOL: begin
                        if (elapsed_us(now_t, run_start_q) > 64'(run_lim_q) || hum < thr_q) begin
                            mode_q       = MODE_WAIT;
                            fan_q        = 1'b0;
                            wait_start_q = now_t;
                        end
                    end
                    MODE_FORCED: begin
                        if (elapsed_us(now_t, run_start_q) > 64'(run_lim_q)) begin
                            mode_q       = MODE_IDLE;
                            fan_q        = 1'b0;
                            last_humid_q = now_t;
                        end
                    end
                    MODE_WAIT: begin
                        if (elapsed_us(now_t, wait_start_q) > 64'(wait_lim_q)) mode_q = MODE_IDLE;
                    end
                endcase
            end
            OP_NONE: ;
        endcase
        case (mode_q)
            MODE_COOL, MODE_FORCED:
                r.remaining_us = time_left(run_lim_q, elapsed_us(now_t, run_start_q));
            MODE_WAIT:
                r.remaining_us = time_left(wait_lim_q, elapsed_us(now_t, wait_start_q));
            default:
                r.remaining_us = time_left(force_int_q, elapsed_us(now_t, last_humid_q));
        endcase
        r.mode      = mode_q;
        r.fan_drive = fan_q;
        r.changed   = mode_q != prev;
        return r;
    endfunction

    // result side: random stalls, plus a long hold-off when a test asks for one
    initial begin : result_ready
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                res_if.ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (!no_stall && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                stall_left = gap_len();
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (reports < REPORT_CAP) begin
                reports++;
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            end
        end
    endtask

    initial begin : result_check
        t_res want;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (reports < REPORT_CAP) begin
                        reports++;
                        $display("%0t ns: result expected none, got mode %0d rem %0d",
                                 $time, res_if.mode, res_if.remaining_us);
                    end
                end else begin
                    want = pending_results.pop_front();
                    check_field("mode", 64'(want.mode), 64'(res_if.mode));
                    check_field("fan_drive", 64'(want.fan_drive), 64'(res_if.fan_drive));
                    check_field("remaining_us", 64'(want.remaining_us),
                                64'(res_if.remaining_us));
                    check_field("changed", 64'(want.changed), 64'(res_if.changed));
                end
            end
        end
    end

    // called just after the clock; presents the item and returns once ready is seen high
    task automatic send_item(input logic [OP_W-1:0] op, input logic [HUM_W-1:0] hum,
                             input logic [TW-1:0] now_t);
        int gap;
        gap = no_gaps ? 0 : gap_len();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid           <= 1'b1;
        item_if.op              <= op;
        item_if.humidity_tenths <= hum;
        item_if.now_us          <= now_t;
        @(posedge i_clk);
        while (item_if.ready !== 1'b1) @(posedge i_clk);
        pending_results.push_back(fan_predict(op, hum, now_t));
    endtask

    // mostly samples, often near the threshold, time moving forward on the scale
    // of the current limits, with occasional backward steps and wild jumps
    task automatic send_random_item();
        logic [OP_W-1:0]  op;
        logic [HUM_W-1:0] hum;
        logic [63:0]      lim;
        logic [63:0]      pace;
        int               r;
        int               h;
        lim = 64'(run_lim_q);
        if (64'(wait_lim_q) > lim) lim = 64'(wait_lim_q);
        if (64'(force_int_q) > lim) lim = 64'(force_int_q);
        pace = lim + (lim >> 1) + 64'd1;
        r = $urandom_range(0, 99);
        if (r < 80)      op = OP_SAMPLE;
        else if (r < 88) op = OP_MAN_ON;
        else if (r < 96) op = OP_MAN_OFF;
        else             op = OP_NONE;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            h = int'(thr_q) + int'($urandom_range(0, 4)) - 2;
            if (h < 0) h = 0;
            if (h > 1023) h = 1023;
            hum = HUM_W'(h);
        end else if (r < 90) begin
            hum = HUM_W'($urandom_range(0, 1000));
        end else begin
            hum = HUM_W'($urandom_range(1001, 1023));
        end
        r = $urandom_range(0, 99);
        if (r < 8)       cur_time = cur_time;
        else if (r < 92) cur_time = cur_time + TW'(rand64() % pace);
        else if (r < 96) cur_time = cur_time - TW'(rand64() % pace);
        else             cur_time = TW'(rand64());
        send_item(op, hum, cur_time);
    endtask

    task automatic wait_for_results();
        item_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_THRESHOLD:  thr_q       = data[HUM_W-1:0];
            CFG_RUN_LIMIT:  run_lim_q   = data;
            CFG_WAIT_LIMIT: wait_lim_q  = data;
            CFG_FORCE_INT:  force_int_q = data;
        endcase
    endtask

    task automatic set_config(input logic [LIMIT_W-1:0] thr_data, input logic [LIMIT_W-1:0] run,
                              input logic [LIMIT_W-1:0] pause, input logic [LIMIT_W-1:0] force_int);
        wait_for_results();
        cfg_write(CFG_THRESHOLD, thr_data);
        cfg_write(CFG_RUN_LIMIT, run);
        cfg_write(CFG_WAIT_LIMIT, pause);
        cfg_write(CFG_FORCE_INT, force_int);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return LIMIT_W'($urandom_range(0, 400));
        if (r < 80) return '0;
        if (r < 90) return LIMIT_MAX;
        return LIMIT_W'(rand64());
    endfunction

    // upper bits of the data bus are junk for the threshold write
    function automatic logic [LIMIT_W-1:0] pick_threshold();
        logic [LIMIT_W-1:0] data;
        int                 r;
        data = LIMIT_W'(rand64());
        r = $urandom_range(0, 99);
        if (r < 70)      data[HUM_W-1:0] = HUM_W'($urandom_range(300, 900));
        else if (r < 80) data[HUM_W-1:0] = '0;
        else if (r < 90) data[HUM_W-1:0] = '1;
        return data;
    endfunction

    // reset register values: every mode, both manual commands, unused op
    task automatic test_directed_defaults();
        logic [TW-1:0] t;
        send_item(OP_SAMPLE, 10'd0, '0);
        send_item(OP_NONE, 10'd1023, TW'(5));
        send_item(OP_SAMPLE, 10'd701, TW'(1000));
        send_item(OP_SAMPLE, 10'd700, TW'(2000));      // equal to threshold keeps cooling
        send_item(OP_MAN_ON, 10'd0, TW'(3000));        // run timer restarts, no change
        t = TW'(64'd3001 + RUN_LIMIT_RST);
        send_item(OP_SAMPLE, 10'd700, t);              // run limit -> waiting
        send_item(OP_SAMPLE, 10'd900, TW'(1000));      // time going backwards
        t = t + TW'(WAIT_LIMIT_RST) + TW'(1);
        send_item(OP_SAMPLE, 10'd900, t);
        t = TW'(64'd1001 + FORCE_INT_RST);
        send_item(OP_SAMPLE, 10'd0, t);                // long idle -> forced run
        t = t + TW'(RUN_LIMIT_RST) + TW'(1);
        send_item(OP_SAMPLE, 10'd1000, t);
        send_item(OP_MAN_ON, 10'd0, t + TW'(7));
        send_item(OP_MAN_OFF, 10'd0, t + TW'(9));
        cur_time = t + TW'(20);
    endtask

    // all-zero and all-ones registers, extreme timestamps
    task automatic test_directed_extremes();
        logic [TW-1:0] t;
        set_config(40'hFF_FFFF_FC00, '0, '0, '0);
        t = cur_time;
        send_item(OP_SAMPLE, 10'd0, t);
        send_item(OP_SAMPLE, 10'd0, t);
        send_item(OP_SAMPLE, 10'd0, t + TW'(1));
        send_item(OP_SAMPLE, 10'd1, t + TW'(1));
        send_item(OP_SAMPLE, 10'd0, t + TW'(1));
        send_item(OP_SAMPLE, 10'd0, t + TW'(2));
        send_item(OP_SAMPLE, 10'd0, t + TW'(2));
        send_item(OP_SAMPLE, 10'd0, t + TW'(3));
        set_config(40'h00_0000_03FF, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
        send_item(OP_SAMPLE, 10'd1023, TIME_MAX);
        send_item(OP_SAMPLE, 10'd1023, '0);
        send_item(OP_MAN_OFF, 10'd512, TW'({1'b1, {(TW-1)/2{2'b01}}}));
        cur_time = TW'(rand64());
    endtask

    // back-to-back items with random result stalls switched off
    task automatic test_full_rate();
        set_config(pick_threshold(), LIMIT_W'($urandom_range(1, 300)),
                   LIMIT_W'($urandom_range(1, 300)), LIMIT_W'($urandom_range(1, 300)));
        no_gaps  = 1'b1;
        no_stall = 1'b1;
        repeat (60) send_random_item();
        no_gaps  = 1'b0;
        no_stall = 1'b0;
    endtask

    // long result hold-off while items keep coming, then a full drain
    task automatic test_back_pressure();
        wait_for_results();
        no_gaps     = 1'b1;
        hold_cycles = 60;
        repeat (30) send_random_item();
        no_gaps = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_phases();
        repeat (6) begin
            set_config(pick_threshold(), pick_limit(), pick_limit(), pick_limit());
            if ($urandom_range(0, 1) == 0) cur_time = TW'(rand64());
            repeat (140) send_random_item();
        end
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        i_cfg_we                <= 1'b0;
        i_cfg_idx               <= CFG_THRESHOLD;
        i_cfg_data              <= '0;
        item_if.valid           <= 1'b0;
        item_if.op              <= OP_SAMPLE;
        item_if.humidity_tenths <= '0;
        item_if.now_us          <= '0;
        thr_q        = THRESHOLD_RST;
        run_lim_q    = RUN_LIMIT_RST;
        wait_lim_q   = WAIT_LIMIT_RST;
        force_int_q  = FORCE_INT_RST;
        mode_q       = MODE_IDLE;
        fan_q        = 1'b0;
        last_humid_q = '0;
        run_start_q  = '0;
        wait_start_q = '0;
        cur_time     = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_directed_extremes();
        test_full_rate();
        test_back_pressure();
        test_random_phases();

        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

>>> sim.f
sv/hfmc_pkg.sv
sv/hfmc_in_if.sv
sv/hfmc_out_if.sv
sv/hfmc_cfg.sv
sv/hfmc_step.sv
sv/humidity_fan_mode_controller.sv
tb/sv/tb.sv
